FILE: hw/rtl/deq_pkg.sv
// Types and codes shared by the deque ring buffer and its checker.
`timescale 1ns / 1ps
package deq_pkg;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [5:0]         out_position;
    logic [1:0]         status;
    logic               last;
  } resp_t;

endpackage

FILE: hw/rtl/double_ended_queue_top.sv
// Bounded double-ended queue held in a ring buffer memory.
// Push, clear and empty/full reports: result registered in the cycle after the transaction.
// Pops: the memory read data is registered, then held until the output register is free.
// List: n = min(count, 32) results, one per cycle from the single read port unless stalled.
// Next request taken only when idle, with no read pending and the output register free.
// Synchronous reset empties the queue; memory contents are not cleared.
`timescale 1ns / 1ps
module double_ended_queue_top #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  deq_pkg::req_t  req,
  output logic           resp_valid,
  input  logic           resp_stall,
  output deq_pkg::resp_t resp
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;

  logic          state;
  logic [AW-1:0] front;
  logic [CW-1:0] count;
  logic [AW-1:0] rptr;
  logic [5:0]    lidx;
  logic [5:0]    lnum;
  logic          pend;
  logic [5:0]    pend_pos;
  logic          pend_last;

  logic          acc, take, out_free, move;
  logic          full, empty;
  logic          is_push, is_pop, imm;
  logic [1:0]    imm_status;
  logic          re, we, list_re, list_end;
  logic [AW-1:0] raddr, waddr;
  logic [AW-1:0] front_dec, back_addr, tail_addr;
  logic [CW:0]   sum_tail, sum_back;
  logic [CW-1:0] count_m1;
  logic [31:0]   count32;
  logic [5:0]    list_n;
  logic [63:0]   wide;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : AW'(a + 1'b1);
  endfunction

  function automatic logic [AW-1:0] ring_wrap(input logic [CW:0] s);
    logic [CW:0] t;
    t = (s >= (CW + 1)'(DEPTH)) ? (s - (CW + 1)'(DEPTH)) : s;
    return t[AW-1:0];
  endfunction

  assign acc      = req_valid && !req_stall;
  assign take     = resp_valid && !resp_stall;
  assign out_free = !resp_valid || take;
  assign move     = pend && out_free;
  assign req_stall = !(state == S_IDLE && !pend && out_free);

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : AW'(front - 1'b1);
  assign count_m1  = count - 1'b1;
  assign sum_tail  = (CW + 1)'(front) + (CW + 1)'(count);
  assign sum_back  = (CW + 1)'(front) + (CW + 1)'(count_m1);
  assign tail_addr = ring_wrap(sum_tail);
  assign back_addr = ring_wrap(sum_back);

  assign count32 = 32'(count);
  assign list_n  = (count32 > 32'(deq_pkg::MAX_RESULTS)) ? 6'(deq_pkg::MAX_RESULTS)
                                                         : count32[5:0];

  assign is_push = (req.req_type == deq_pkg::REQ_PUSH_FRONT) ||
                   (req.req_type == deq_pkg::REQ_PUSH_BACK);
  assign is_pop  = (req.req_type == deq_pkg::REQ_POP_FRONT) ||
                   (req.req_type == deq_pkg::REQ_POP_BACK);

  always_comb begin
    imm        = 1'b0;
    imm_status = deq_pkg::STAT_OK;
    unique case (req.req_type) inside
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
        imm        = 1'b1;
        imm_status = full ? deq_pkg::STAT_FULL : deq_pkg::STAT_OK;
      end
      deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK, deq_pkg::REQ_LIST: begin
        imm        = empty;
        imm_status = deq_pkg::STAT_EMPTY;
      end
      deq_pkg::REQ_CLEAR: begin
        imm = 1'b1;
      end
      default: begin
        imm = 1'b0;
      end
    endcase
  end

  assign we      = acc && is_push && !full;
  assign waddr   = (req.req_type == deq_pkg::REQ_PUSH_FRONT) ? front_dec : tail_addr;
  assign list_re = (state == S_LIST) && (!pend || move);
  assign list_end = (lidx + 6'd1 == lnum);
  assign re      = (acc && is_pop && !empty) || list_re;
  assign raddr   = (state == S_LIST) ? rptr :
                   (req.req_type == deq_pkg::REQ_POP_FRONT) ? front : back_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= DATA_WIDTH'($unsigned(req.push_value));
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign wide = 64'(signed'(rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      count      <= '0;
      pend       <= 1'b0;
      resp_valid <= 1'b0;
    end else begin
      if (re) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end

      if (move || (acc && imm)) begin
        resp_valid <= 1'b1;
      end else if (take) begin
        resp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (req.req_type)
              deq_pkg::REQ_PUSH_FRONT: begin
                if (!full) begin
                  front <= front_dec;
                  count <= count + 1'b1;
                end
              end
              deq_pkg::REQ_PUSH_BACK: begin
                if (!full) begin
                  count <= count + 1'b1;
                end
              end
              deq_pkg::REQ_POP_FRONT: begin
                if (!empty) begin
                  front <= ring_inc(front);
                  count <= count_m1;
                end
              end
              deq_pkg::REQ_POP_BACK: begin
                if (!empty) begin
                  count <= count_m1;
                end
              end
              deq_pkg::REQ_LIST: begin
                if (!empty) begin
                  state <= S_LIST;
                end
              end
              deq_pkg::REQ_CLEAR: begin
                front <= '0;
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LIST: begin
          if (list_re && list_end) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && req.req_type == deq_pkg::REQ_LIST) begin
      rptr <= front;
      lidx <= '0;
      lnum <= list_n;
    end else if (list_re) begin
      rptr <= ring_inc(rptr);
      lidx <= lidx + 6'd1;
    end

    if (list_re) begin
      pend_pos  <= lidx + 6'd1;
      pend_last <= list_end;
    end else if (acc && is_pop) begin
      pend_pos  <= '0;
      pend_last <= 1'b1;
    end

    if (move) begin
      resp.out_value    <= wide[31:0];
      resp.out_position <= pend_pos;
      resp.status       <= deq_pkg::STAT_OK;
      resp.last         <= pend_last;
    end else if (acc && imm) begin
      resp.out_value    <= '0;
      resp.out_position <= '0;
      resp.status       <= imm_status;
      resp.last         <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/deq_checker.sv
// Port-level checks for the deque ring buffer, bound to the top level.
`timescale 1ns / 1ps
module deq_checker (
  input logic           clk,
  input logic           rst,
  input logic           resp_valid,
  input logic           resp_stall,
  input deq_pkg::resp_t resp
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_stall |=> resp_valid && $stable(resp))
    else $error("stalled transaction changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !resp_valid)
    else $error("result after reset");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.status != deq_pkg::STAT_OK |->
      resp.last && resp.out_value == '0 && resp.out_position == '0)
    else $error("malformed error result");

  a_list_ok: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp.out_position != '0 |->
      resp.status == deq_pkg::STAT_OK && resp.out_position <= 6'd32)
    else $error("bad list entry");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
  .clk        (clk),
  .rst        (rst),
  .resp_valid (resp_valid),
  .resp_stall (resp_stall),
  .resp       (resp)
);

FILE: sim/tb_double_ended_queue_top.sv
// Self-checking testbench for the deque ring buffer: table-driven directed requests, then random.
`timescale 1ns / 1ps
module tb_double_ended_queue_top;

  localparam int QDEPTH = 32;
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;
  localparam logic [2:0] REQ_BY_SLOT [7] = '{deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK,
                                             deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK,
                                             deq_pkg::REQ_LIST, deq_pkg::REQ_CLEAR,
                                             REQ_SPARE_6};
  localparam deq_pkg::resp_t R_OK    = '{32'sd0, 6'd0, deq_pkg::STAT_OK, 1'b1};
  localparam deq_pkg::resp_t R_EMPTY = '{32'sd0, 6'd0, deq_pkg::STAT_EMPTY, 1'b1};
  localparam deq_pkg::resp_t R_NONE  = '0;

  typedef struct packed {
    deq_pkg::req_t  rq;
    logic           typed;
    deq_pkg::resp_t want;
  } plan_row_t;

  localparam int PLAN_LEN = 23;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{deq_pkg::REQ_POP_FRONT, 32'sd0}, 1'b1, R_EMPTY},
    '{'{deq_pkg::REQ_POP_BACK, 32'sd0}, 1'b1, R_EMPTY},
    '{'{deq_pkg::REQ_LIST, 32'sd0}, 1'b1, R_EMPTY},
    '{'{REQ_SPARE_6, 32'sh7fffffff}, 1'b0, R_NONE},
    '{'{REQ_SPARE_7, 32'sh80000000}, 1'b0, R_NONE},
    '{'{deq_pkg::REQ_PUSH_FRONT, 32'sh7fffffff}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_PUSH_BACK, 32'sh80000000}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_PUSH_FRONT, 32'sd0}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_PUSH_BACK, -32'sd1}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_LIST, 32'sd0}, 1'b0, R_NONE},
    '{'{deq_pkg::REQ_POP_FRONT, 32'sd0}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_POP_BACK, 32'sd0}, 1'b1, '{-32'sd1, 6'd0, deq_pkg::STAT_OK, 1'b1}},
    '{'{deq_pkg::REQ_POP_FRONT, 32'sd0}, 1'b1,
      '{32'sh7fffffff, 6'd0, deq_pkg::STAT_OK, 1'b1}},
    '{'{deq_pkg::REQ_POP_BACK, 32'sd0}, 1'b1,
      '{32'sh80000000, 6'd0, deq_pkg::STAT_OK, 1'b1}},
    '{'{deq_pkg::REQ_POP_FRONT, 32'sd0}, 1'b1, R_EMPTY},
    '{'{deq_pkg::REQ_PUSH_BACK, 32'sh55555555}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_PUSH_FRONT, 32'shaaaaaaaa}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_LIST, 32'sd0}, 1'b0, R_NONE},
    '{'{deq_pkg::REQ_CLEAR, 32'sd0}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_LIST, 32'sd0}, 1'b1, R_EMPTY},
    '{'{deq_pkg::REQ_PUSH_BACK, 32'sd1}, 1'b1, R_OK},
    '{'{deq_pkg::REQ_POP_FRONT, 32'sd0}, 1'b1, '{32'sd1, 6'd0, deq_pkg::STAT_OK, 1'b1}},
    '{'{deq_pkg::REQ_POP_BACK, 32'sd0}, 1'b1, R_EMPTY}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  deq_pkg::req_t  req = '0;
  logic           resp_valid;
  logic           resp_stall = 1'b0;
  deq_pkg::resp_t resp;

  logic [31:0]    ring_copy [QDEPTH];
  logic [4:0]     ring_head = '0;
  int             ring_fill = 0;
  deq_pkg::resp_t deque_results [$];
  deq_pkg::resp_t expected_resps [$];
  int             errors = 0;
  bit             no_gaps = 1'b0;
  bit             long_hold_go = 1'b0;

  double_ended_queue_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("double_ended_queue_top: mismatch");
    $finish;
  end

  // Applies one request to the local deque copy and lists the results it yields.
  function automatic void deque_apply(input deq_pkg::req_t r);
    deq_pkg::resp_t x;
    logic [4:0]     idx;
    int             n;
    deque_results.delete();
    x = R_OK;
    case (r.req_type) inside
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
        if (ring_fill == QDEPTH) begin
          x.status = deq_pkg::STAT_FULL;
        end else begin
          if (r.req_type == deq_pkg::REQ_PUSH_FRONT) begin
            ring_head = ring_head - 5'd1;
            idx = ring_head;
          end else begin
            idx = ring_head + ring_fill[4:0];
          end
          ring_copy[idx] = r.push_value;
          ring_fill++;
        end
        deque_results.push_back(x);
      end
      deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
        if (ring_fill == 0) begin
          x.status = deq_pkg::STAT_EMPTY;
        end else begin
          if (r.req_type == deq_pkg::REQ_POP_FRONT) begin
            x.out_value = ring_copy[ring_head];
            ring_head = ring_head + 5'd1;
          end else begin
            idx = ring_head + ring_fill[4:0] - 5'd1;
            x.out_value = ring_copy[idx];
          end
          ring_fill--;
        end
        deque_results.push_back(x);
      end
      deq_pkg::REQ_LIST: begin
        if (ring_fill == 0) begin
          deque_results.push_back(R_EMPTY);
        end else begin
          n = (ring_fill < deq_pkg::MAX_RESULTS) ? ring_fill : deq_pkg::MAX_RESULTS;
          for (int i = 0; i < n; i++) begin
            idx = ring_head + i[4:0];
            x.out_value = ring_copy[idx];
            x.out_position = 6'(i + 1);
            x.last = (i + 1 == n);
            deque_results.push_back(x);
          end
        end
      end
      deq_pkg::REQ_CLEAR: begin
        ring_head = '0;
        ring_fill = 0;
        deque_results.push_back(x);
      end
      default: ;
    endcase
  endfunction

  function automatic deq_pkg::req_t random_request(input int mode);
    deq_pkg::req_t r;
    int            w [7];
    int            pick;
    int            acc;
    int            slot;
    case (mode)
      0: w = '{38, 38, 8, 8, 6, 1, 1};
      1: w = '{8, 8, 36, 36, 8, 2, 2};
      2: w = '{22, 22, 22, 22, 8, 2, 2};
      default: w = '{20, 20, 15, 15, 28, 1, 1};
    endcase
    pick = $urandom_range(0, 99);
    acc = 0;
    slot = -1;
    for (int i = 0; i < 7; i++) begin
      acc += w[i];
      if (pick < acc && slot < 0) slot = i;
    end
    r.req_type = REQ_BY_SLOT[slot];
    if (r.req_type == REQ_SPARE_6 && $urandom_range(0, 1) == 1) r.req_type = REQ_SPARE_7;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: r.push_value = 32'sd0;
        1: r.push_value = -32'sd1;
        2: r.push_value = 32'sh7fffffff;
        default: r.push_value = 32'sh80000000;
      endcase
    end else begin
      r.push_value = $urandom();
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request, waits for the transaction, then queues what it should yield.
  task automatic offer_request(input deq_pkg::req_t r, input bit typed,
                               input deq_pkg::resp_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    deque_apply(r);
    if (typed) begin
      expected_resps.push_back(want);
    end else begin
      foreach (deque_results[i]) expected_resps.push_back(deque_results[i]);
    end
  endtask

  task automatic random_phase(input int target);
    int            sent;
    int            mode;
    int            len;
    deq_pkg::req_t r;
    sent = 0;
    while (sent < target) begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(8, 48);
      no_gaps = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len && sent < target; k++) begin
        r = random_request(mode);
        offer_request(r, 1'b0, R_NONE);
        if (r.req_type != REQ_SPARE_6 && r.req_type != REQ_SPARE_7) sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_result(input deq_pkg::resp_t got);
    deq_pkg::resp_t want;
    if (expected_resps.size() == 0) begin
      $display("%0t: unexpected transaction value=%0d pos=%0d status=%0d last=%0b",
               $time, got.out_value, got.out_position, got.status, got.last);
      errors++;
    end else begin
      want = expected_resps.pop_front();
      if (got !== want) begin
        $display("%0t: expected value=%0d pos=%0d status=%0d last=%0b", $time,
                 want.out_value, want.out_position, want.status, want.last);
        $display("%0t: actual   value=%0d pos=%0d status=%0d last=%0b", $time,
                 got.out_value, got.out_position, got.status, got.last);
        errors++;
      end
    end
  endtask

  initial begin : result_side
    int stall_left;
    int free_left;
    int pick;
    stall_left = 0;
    free_left = 0;
    forever begin
      @(posedge clk);
      if (resp_valid && !resp_stall) check_result(resp);
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        stall_left = 250;
        free_left = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) free_left = $urandom_range(1, 6);
        else if (pick < 80) stall_left = $urandom_range(1, 3);
        else if (pick < 93) stall_left = $urandom_range(4, 20);
        else free_left = $urandom_range(30, 90);
      end
      if (stall_left > 0) begin
        stall_left--;
        resp_stall <= 1'b1;
      end else begin
        free_left--;
        resp_stall <= 1'b0;
      end
    end
  end

  initial begin : request_side
    deq_pkg::req_t r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PLAN[i]) offer_request(PLAN[i].rq, PLAN[i].typed, PLAN[i].want);

    // hold the output off while pushes keep coming: fills the deque and backs up the input
    long_hold_go = 1'b1;
    no_gaps = 1'b1;
    for (int k = 0; k < 40; k++) begin
      r.req_type = ($urandom_range(0, 1) == 1) ? deq_pkg::REQ_PUSH_FRONT
                                                : deq_pkg::REQ_PUSH_BACK;
      r.push_value = $urandom();
      offer_request(r, 1'b0, R_NONE);
    end
    r.req_type = deq_pkg::REQ_LIST;
    offer_request(r, 1'b0, R_NONE);
    no_gaps = 1'b0;

    random_phase(360);
    req_valid <= 1'b0;

    while (expected_resps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("double_ended_queue_top: match");
    end else begin
      $display("double_ended_queue_top: mismatch");
    end
    $finish;
  end

endmodule
